FILE: rtl/pdh_pkg.sv
// Shared types, constants and the fade function of the pixel difference highlighter.
package pdh_pkg;

  localparam int unsigned MaxDim = 4096;
  localparam int unsigned DimW   = $clog2(MaxDim + 1);
  localparam int unsigned PosW   = $clog2(MaxDim);
  localparam int unsigned RegW   = 13;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned CntW   = 25;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PixW   = 32;
  localparam int unsigned ChW    = 8;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam int unsigned FadeMul   = 55;
  localparam int unsigned FadeOfs   = 255 * 45 + 50;
  localparam int unsigned FadeShift = 22;
  localparam int unsigned FadeRecip = (1 << FadeShift) / 100 + 1;

  typedef enum logic [2:0] {
    RegFrameW   = 3'd0,
    RegFrameH   = 3'd1,
    RegBeforeW  = 3'd2,
    RegBeforeH  = 3'd3,
    RegAfterW   = 3'd4,
    RegAfterH   = 3'd5,
    RegThresh   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [PosW-1:0] col_last;
    logic [PosW-1:0] row_last;
    logic [RegW-1:0] before_w;
    logic [RegW-1:0] before_h;
    logic [RegW-1:0] after_w;
    logic [RegW-1:0] after_h;
    logic [ThrW-1:0] thresh;
  } cfg_t;

  typedef struct packed {
    logic in_before;
    logic in_after;
    logic first;
    logic last;
  } pos_t;

  // Divide by 100 through a reciprocal; exact for every 8-bit channel value.
  function automatic logic [ChW-1:0] fade_f(input logic [ChW-1:0] c);
    logic [14:0] num;
    logic [30:0] prod;
    num  = 15'(c) * 15'(FadeMul) + 15'(FadeOfs);
    prod = 31'(num) * 31'(FadeRecip);
    return prod[FadeShift+ChW-1:FadeShift];
  endfunction

endpackage

FILE: rtl/pdh_cfg_regs.sv
// APB configuration registers with frame size clamping.
module pdh_cfg_regs import pdh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [RegW-1:0] frame_w_q, frame_h_q, before_w_q, before_h_q, after_w_q, after_h_q;
  logic [ThrW-1:0] thresh_q;
  logic [2:0]      idx;
  logic            wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q  <= RegW'(1);
      frame_h_q  <= RegW'(1);
      before_w_q <= '0;
      before_h_q <= '0;
      after_w_q  <= '0;
      after_h_q  <= '0;
      thresh_q   <= '0;
    end else if (wr_en) begin
      case (idx)
        RegFrameW:  frame_w_q  <= pwdata[RegW-1:0];
        RegFrameH:  frame_h_q  <= pwdata[RegW-1:0];
        RegBeforeW: before_w_q <= pwdata[RegW-1:0];
        RegBeforeH: before_h_q <= pwdata[RegW-1:0];
        RegAfterW:  after_w_q  <= pwdata[RegW-1:0];
        RegAfterH:  after_h_q  <= pwdata[RegW-1:0];
        RegThresh:  thresh_q   <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegFrameW:  prdata = DataW'(frame_w_q);
      RegFrameH:  prdata = DataW'(frame_h_q);
      RegBeforeW: prdata = DataW'(before_w_q);
      RegBeforeH: prdata = DataW'(before_h_q);
      RegAfterW:  prdata = DataW'(after_w_q);
      RegAfterH:  prdata = DataW'(after_h_q);
      RegThresh:  prdata = DataW'(thresh_q);
      default:    prdata = '0;
    endcase
  end

  function automatic logic [PosW-1:0] last_pos(input logic [RegW-1:0] v);
    logic [DimW-1:0] d;
    if (v == '0) begin
      d = DimW'(1);
    end else if (v > RegW'(MaxDim)) begin
      d = DimW'(MaxDim);
    end else begin
      d = DimW'(v);
    end
    d = d - DimW'(1);
    return d[PosW-1:0];
  endfunction

  always_comb begin
    cfg_o.col_last = last_pos(frame_w_q);
    cfg_o.row_last = last_pos(frame_h_q);
    cfg_o.before_w = before_w_q;
    cfg_o.before_h = before_h_q;
    cfg_o.after_w  = after_w_q;
    cfg_o.after_h  = after_h_q;
    cfg_o.thresh   = thresh_q;
  end

endmodule

FILE: rtl/pdh_raster.sv
// Raster position tracker that classifies each accepted pixel position.
module pdh_raster import pdh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  cfg_t cfg_i,
  output pos_t pos_o
);

  logic [PosW-1:0] col_q, col_d, row_q, row_d;
  logic            row_end;

  assign row_end = col_q >= cfg_i.col_last;

  always_comb begin
    pos_o.in_before = (RegW'(col_q) < cfg_i.before_w) && (RegW'(row_q) < cfg_i.before_h);
    pos_o.in_after  = (RegW'(col_q) < cfg_i.after_w) && (RegW'(row_q) < cfg_i.after_h);
    pos_o.first     = (col_q == '0) && (row_q == '0);
    pos_o.last      = row_end && (row_q >= cfg_i.row_last);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (pos_o.last) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + PosW'(1);
      end else begin
        col_d = col_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: rtl/pdh_pixel_calc.sv
// Per-pixel channel compare, giving opaque red on a change and a fade toward white otherwise.
module pdh_pixel_calc import pdh_pkg::*; (
  input  logic [PixW-1:0] before_i,
  input  logic [PixW-1:0] after_i,
  input  logic            in_before_i,
  input  logic            in_after_i,
  input  logic [ThrW-1:0] thresh_i,
  output logic [PixW-1:0] rgba_o,
  output logic            changed_o
);

  logic [PixW-1:0] bp, ap;
  logic [3:0]      over;
  logic [ChW-1:0]  b, a, d;

  assign bp = in_before_i ? before_i : '0;
  assign ap = in_after_i ? after_i : '0;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      b = bp[k*ChW +: ChW];
      a = ap[k*ChW +: ChW];
      d = (b > a) ? (b - a) : (a - b);
      over[k] = d > thresh_i;
    end
  end

  assign changed_o = |over;

  always_comb begin
    if (changed_o) begin
      rgba_o = {8'hFF, 8'h00, 8'h00, 8'hFF};
    end else begin
      rgba_o = {ap[3*ChW +: ChW], fade_f(ap[2*ChW +: ChW]),
                fade_f(ap[ChW +: ChW]), fade_f(ap[0 +: ChW])};
    end
  end

endmodule

FILE: rtl/pixel_diff_highlighter.sv
// Top level of the pixel difference highlighter with its two register stages.
// An accepted word goes into the input register, then the result register offers it.
// Throughput: one word per cycle, limited only by the output side's tready.
// The input register and the result register each hold one word.
// Reset clears the position, the change count, both valid flags and
// returns the configuration registers to their reset values.
module pixel_diff_highlighter import pdh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: before_pixel[31:0], after_pixel[63:32].
  input  logic [63:0]      s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // Fields from bit 0: out_red, out_green, out_blue, out_alpha, changed_count[56:32], zeros.
  output logic [63:0]      m_axis_tdata,
  // Field: pixel_changed.
  output logic             m_axis_tuser,
  // Field: frame_end.
  output logic             m_axis_tlast
);

  cfg_t            cfg;
  pos_t            pos, pos_q;
  logic            in_valid_q, out_valid_q;
  logic            in_acc, adv;
  logic [PixW-1:0] before_q, after_q, rgba, rgba_q;
  logic            changed, changed_q, last_q;
  logic [CntW-1:0] tally_q, tally_d, base;

  pdh_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  pdh_raster u_raster (
    .clk_i, .rst_ni,
    .step_i(in_acc),
    .cfg_i (cfg),
    .pos_o (pos)
  );

  pdh_pixel_calc u_calc (
    .before_i   (before_q),
    .after_i    (after_q),
    .in_before_i(pos_q.in_before),
    .in_after_i (pos_q.in_after),
    .thresh_i   (cfg.thresh),
    .rgba_o     (rgba),
    .changed_o  (changed)
  );

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign base    = pos_q.first ? '0 : tally_q;
  assign tally_d = (changed && base != CntMax) ? base + CntW'(1) : base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tally_q     <= '0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        tally_q     <= tally_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      before_q <= s_axis_tdata[PixW-1:0];
      after_q  <= s_axis_tdata[2*PixW-1:PixW];
      pos_q    <= pos;
    end
    if (adv) begin
      rgba_q    <= rgba;
      changed_q <= changed;
      last_q    <= pos_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(64 - PixW - CntW){1'b0}}, tally_q, rgba_q};
  assign m_axis_tuser  = changed_q;
  assign m_axis_tlast  = last_q;

endmodule

FILE: rtl/pdh_checker.sv
// Port-level checker for the pixel difference highlighter and its bind.
module pdh_checker import pdh_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [63:0]      m_axis_tdata,
  input logic             m_axis_tuser,
  input logic             m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == 32'hFF0000FF)
    else $error("changed pixel is not opaque red");

  a_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[7:0] >= 8'd115 && m_axis_tdata[15:8] >= 8'd115 &&
      m_axis_tdata[23:16] >= 8'd115)
    else $error("faded channel below its floor");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[56:32] != 25'd0)
    else $error("changed pixel with a zero count");

endmodule

bind pixel_diff_highlighter pdh_checker u_pdh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

FILE: tb/sv/pixel_diff_highlighter_tb.sv
// Self-checking pixel difference highlighter testbench: APB setup, fixed and random stream traffic, a predictor.
module pixel_diff_highlighter_tb;
  import pdh_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 110;
  localparam int unsigned RandPhases = 8;

  typedef struct packed {
    logic [PixW-1:0] after_px;
    logic [PixW-1:0] before_px;
  } pixel_pair_t;

  typedef struct packed {
    logic [ChW-1:0]  red;
    logic [ChW-1:0]  green;
    logic [ChW-1:0]  blue;
    logic [ChW-1:0]  alpha;
    logic            changed;
    logic [CntW-1:0] count;
    logic            frame_end;
  } diff_pixel_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // Fields from bit 0: before_pixel[31:0], after_pixel[63:32].
  logic [63:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // Fields from bit 0: out_red, out_green, out_blue, out_alpha, changed_count[56:32], zeros.
  logic [63:0]      m_axis_tdata;
  // Field: pixel_changed.
  logic             m_axis_tuser;
  // Field: frame_end.
  logic             m_axis_tlast;

  pixel_diff_highlighter dut (.*);

  // Shadow copy of the configuration and of the position and count state.
  logic [RegW-1:0] frame_w_q = 13'd1;
  logic [RegW-1:0] frame_h_q = 13'd1;
  logic [RegW-1:0] before_w_q = '0;
  logic [RegW-1:0] before_h_q = '0;
  logic [RegW-1:0] after_w_q = '0;
  logic [RegW-1:0] after_h_q = '0;
  logic [ThrW-1:0] thresh_q = '0;
  logic [PosW-1:0] col_q = '0;
  logic [PosW-1:0] row_q = '0;
  logic [CntW-1:0] tally_q = '0;

  pixel_pair_t pixel_pairs[$];
  diff_pixel_t diff_expected[$];
  int          results_due = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          sink_stall = 0;
  bit          calm = 1'b0;

  function automatic int unsigned clamp_size(input logic [RegW-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > MaxDim) begin
      return MaxDim;
    end
    return v;
  endfunction

  function automatic logic [ChW-1:0] whiten(input logic [ChW-1:0] c);
    int unsigned v;
    v = (int'(c) * 55 + 255 * 45 + 50) / 100;
    return v[ChW-1:0];
  endfunction

  function automatic diff_pixel_t highlight_pixel(input logic [PixW-1:0] before_px,
                                                  input logic [PixW-1:0] after_px);
    diff_pixel_t     res;
    int unsigned     w;
    int unsigned     h;
    logic [PixW-1:0] bp;
    logic [PixW-1:0] ap;
    int              b;
    int              a;
    int              d;
    logic            row_end;
    w = clamp_size(frame_w_q);
    h = clamp_size(frame_h_q);
    bp = (col_q < before_w_q && row_q < before_h_q) ? before_px : '0;
    ap = (col_q < after_w_q && row_q < after_h_q) ? after_px : '0;
    if (col_q == 0 && row_q == 0) begin
      tally_q = '0;
    end
    res = '0;
    for (int k = 0; k < 4; k++) begin
      b = bp[8*k +: 8];
      a = ap[8*k +: 8];
      d = (b > a) ? b - a : a - b;
      if (d > int'(thresh_q)) begin
        res.changed = 1'b1;
      end
    end
    if (res.changed) begin
      if (tally_q != CntMax) begin
        tally_q = tally_q + 1'b1;
      end
      res.red = 8'd255;
      res.alpha = 8'd255;
    end else begin
      res.red = whiten(ap[7:0]);
      res.green = whiten(ap[15:8]);
      res.blue = whiten(ap[23:16]);
      res.alpha = ap[31:24];
    end
    res.count = tally_q;
    row_end = col_q >= w - 1;
    res.frame_end = row_end && row_q >= h - 1;
    if (res.frame_end) begin
      col_q = '0;
      row_q = '0;
    end else if (row_end) begin
      col_q = '0;
      row_q = row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Pixel pair sender.
  always @(posedge clk_i) begin : sender
    pixel_pair_t pp;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        diff_expected.push_back(highlight_pixel(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_pairs.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 8);
        s_axis_tvalid <= 1'b0;
      end else if (pixel_pairs.size() != 0) begin
        pp = pixel_pairs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pp.after_px, pp.before_px};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver and checker.
  always @(posedge clk_i) begin : receiver
    diff_pixel_t got;
    diff_pixel_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.red = m_axis_tdata[7:0];
        got.green = m_axis_tdata[15:8];
        got.blue = m_axis_tdata[23:16];
        got.alpha = m_axis_tdata[31:24];
        got.count = m_axis_tdata[56:32];
        got.changed = m_axis_tuser;
        got.frame_end = m_axis_tlast;
        if (diff_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected word: %p", got);
          end
        end else begin
          want = diff_expected.pop_front();
          results_due--;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.alpha !== want.alpha || got.changed !== want.changed ||
              got.count !== want.count || got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected %p", want);
              $display("          actual   %p", got);
            end
          end
        end
      end
      if (sink_stall != 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [RegW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(idx) << 2;
    pwdata <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegFrameW:  frame_w_q = value;
      RegFrameH:  frame_h_q = value;
      RegBeforeW: before_w_q = value;
      RegBeforeH: before_h_q = value;
      RegAfterW:  after_w_q = value;
      RegAfterH:  after_h_q = value;
      RegThresh:  thresh_q = value[ThrW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(input logic [RegW-1:0] fw, input logic [RegW-1:0] fh,
                           input logic [RegW-1:0] bw, input logic [RegW-1:0] bh,
                           input logic [RegW-1:0] aw, input logic [RegW-1:0] ah,
                           input logic [RegW-1:0] thr);
    write_reg(RegFrameW, fw);
    write_reg(RegFrameH, fh);
    write_reg(RegBeforeW, bw);
    write_reg(RegBeforeH, bh);
    write_reg(RegAfterW, aw);
    write_reg(RegAfterH, ah);
    write_reg(RegThresh, thr);
  endtask

  task automatic queue_pair(input logic [PixW-1:0] bp, input logic [PixW-1:0] ap);
    pixel_pairs.push_back('{after_px: ap, before_px: bp});
    results_due++;
  endtask

  task automatic drain;
    while (results_due != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [RegW-1:0] pick_frame_dim;
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 13'h1FFF;
      2: return 13'(MaxDim);
      default: return 13'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [RegW-1:0] pick_image_dim(input logic [RegW-1:0] frame_dim);
    if ($urandom_range(0, 9) == 0) begin
      return 13'($urandom);
    end
    return 13'($urandom_range(0, clamp_size(frame_dim) + 2));
  endfunction

  task automatic queue_random_pairs(input int n);
    logic [PixW-1:0] bp;
    logic [PixW-1:0] ap;
    int              spread;
    for (int i = 0; i < n; i++) begin
      bp = $urandom;
      ap = bp;
      spread = $urandom_range(0, 1) ? 3 : 20;
      if ($urandom_range(0, 4) == 0) begin
        ap = $urandom;
      end else begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 1)) begin
            ap[8*k +: 8] = bp[8*k +: 8] + 8'($urandom_range(0, 2 * spread)) - 8'(spread);
          end
        end
      end
      queue_pair(bp, ap);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: both images are empty, so every pixel reads as zero.
    queue_pair(32'hFFFF_FFFF, 32'h1234_5678);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
    drain();

    // Borders of both images, full-scale channel differences.
    set_sizes(13'd5, 13'd2, 13'd4, 13'd2, 13'd5, 13'd1, 13'd0);
    queue_pair(32'h0000_0000, 32'h0000_0000);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
    queue_pair(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    queue_pair(32'h0000_0001, 32'h0000_0000);
    queue_pair(32'h0000_0100, 32'h0000_0000);
    queue_pair(32'h0001_0000, 32'h0000_0000);
    queue_pair(32'h0100_0000, 32'h0000_0000);
    queue_pair(32'h0000_0000, 32'h8080_8080);
    drain();

    // Zero frame width, oversized height and image sizes, largest threshold.
    set_sizes(13'd0, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'hFF);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
    queue_pair(32'h7F80_7F80, 32'h807F_807F);
    queue_pair(32'h1234_5678, 32'h8765_4321);
    drain();

    // Shrinking the frame mid-frame, and differences right at the threshold.
    set_sizes(13'd3, 13'd1, 13'(MaxDim), 13'(MaxDim), 13'(MaxDim), 13'(MaxDim), 13'd1);
    queue_pair(32'h1010_1010, 32'h1111_1111);
    queue_pair(32'h1010_1010, 32'h1012_1010);
    queue_pair(32'hFF00_FF00, 32'hFE01_FE01);
    queue_pair(32'h0000_00FF, 32'h0000_00FD);
    queue_pair(32'h4000_0000, 32'h3E00_0000);
    drain();

    for (int p = 0; p < RandPhases; p++) begin : random_phases
      logic [RegW-1:0] fw;
      logic [RegW-1:0] fh;
      fw = pick_frame_dim();
      fh = pick_frame_dim();
      calm = (p == RandPhases - 1);
      set_sizes(fw, fh, pick_image_dim(fw), pick_image_dim(fh), pick_image_dim(fw),
                pick_image_dim(fh),
                $urandom_range(0, 5) == 0 ? 13'($urandom_range(0, 255))
                                          : 13'($urandom_range(0, 12)));
      if (p == 2) begin
        queue_random_pairs(PhaseItems / 2);
        drain();
        queue_random_pairs(PhaseItems - PhaseItems / 2);
      end else begin
        queue_random_pairs(PhaseItems);
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && diff_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: pixel_diff_highlighter.f
rtl/pdh_pkg.sv
rtl/pdh_cfg_regs.sv
rtl/pdh_raster.sv
rtl/pdh_pixel_calc.sv
rtl/pixel_diff_highlighter.sv
rtl/pdh_checker.sv
tb/sv/pixel_diff_highlighter_tb.sv
